@@ hw/rtl/sha1_message_digest_unit_assert.svh @@
// Assertion macros shared by the SHA-1 digest unit modules.
`ifndef SHA1_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define SHA1MD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that a condition never holds at a clock edge outside reset.
`define SHA1MD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define SHA1MD_ASSERT(lbl, clk, rstn, prop, msg)

`define SHA1MD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ hw/rtl/sha1md_pkg.sv @@
// Types, constants and helper functions of the SHA-1 digest unit.
package sha1md_pkg;

    localparam int NUM_H       = 5;
    localparam int SCHED_DEPTH = 16;
    localparam int ROUNDS      = 80;

    typedef logic [31:0] word_t;
    typedef logic [NUM_H-1:0][31:0] chain_t;

    // Element 0 holds H0.
    localparam chain_t SHA1_IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                  32'hefcdab89, 32'h67452301};

    localparam word_t K_00_19 = 32'h5A827999;
    localparam word_t K_20_39 = 32'h6ED9EBA1;
    localparam word_t K_40_59 = 32'h8F1BBCDC;
    localparam word_t K_60_79 = 32'hCA62C1D6;

    localparam word_t PAD_MARKER = 32'h8000_0000;

    // Requests from the message sequencer to the compression core.
    typedef struct packed {
        logic  load;
        word_t load_word;
        logic  start;
        logic  restart;
    } ctl_t;

    // Core status back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } sts_t;

    // Keeps the valid top bytes of a short last word and puts the marker byte after them.
    function automatic word_t last_word_pad(word_t w, logic [1:0] nb);
        word_t r;
        unique case (nb)
            2'd0: r = PAD_MARKER;
            2'd1: r = (w & 32'hFF00_0000) | 32'h0080_0000;
            2'd2: r = (w & 32'hFFFF_0000) | 32'h0000_8000;
            2'd3: r = (w & 32'hFFFF_FF00) | 32'h0000_0080;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/sha1md_core.sv @@
// SHA-1 compression core: message schedule shift line, one round per cycle, chaining words.
`include "sha1_message_digest_unit_assert.svh"

module sha1md_core
    import sha1md_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  ctl_t   ctl,
    output sts_t   sts,
    output chain_t chain
);

    typedef enum logic [2:0] {
        CS_IDLE  = 3'b001,
        CS_ROUND = 3'b010,
        CS_FOLD  = 3'b100
    } core_state_t;

    core_state_t state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    word_t       sched_reg [SCHED_DEPTH];
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    chain_t      h_reg;

    word_t w_mix, w_new, f_val, k_val, t_sum;

    // The shift line holds W[t] .. W[t+15] at round t, so the schedule taps are fixed.
    assign w_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb begin
        priority if (cnt_reg < 7'd20) begin
            f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k_val = K_00_19;
        end else if (cnt_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_20_39;
        end else if (cnt_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            k_val = K_40_59;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_60_79;
        end
    end

    assign t_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + sched_reg[0];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (ctl.start) begin
                    state_next = CS_ROUND;
                    cnt_next   = '0;
                end
            end
            CS_ROUND: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(ROUNDS - 1)) begin
                    state_next = CS_FOLD;
                    cnt_next   = '0;
                end
            end
            CS_FOLD: begin
                state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load || state_reg == CS_ROUND) begin
            for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[SCHED_DEPTH-1] <= ctl.load ? ctl.load_word : w_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start && state_reg == CS_IDLE) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (state_reg == CS_ROUND) begin
            a_reg <= t_sum;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.restart) begin
            h_reg <= SHA1_IV;
        end else if (state_reg == CS_FOLD) begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    assign sts.busy = (state_reg != CS_IDLE);
    assign sts.done = (state_reg == CS_FOLD);
    assign chain    = h_reg;

    `SHA1MD_ASSERT(a_fold_after_last_round, aclk, aresetn, state_reg == CS_FOLD |-> $past(cnt_reg) == 7'(ROUNDS - 1), "fold without a full set of rounds")
    `SHA1MD_ASSERT_NEVER(a_load_while_busy, aclk, aresetn, (ctl.load || ctl.start) && state_reg != CS_IDLE, "schedule load or start during compression")
    `SHA1MD_ASSERT(a_round_count_range, aclk, aresetn, cnt_reg < 7'(ROUNDS), "round counter out of range")

endmodule

@@ hw/rtl/sha1_message_digest_unit.sv @@
// SHA-1 digest unit: message word intake, padding sequencer and digest output.
//
// Streams a message in as 32-bit big-endian beats and returns its SHA-1 digest as five
// beats, H0 first, m_final_result marking the fifth. After a beat that is not last and
// does not complete a 512-bit block, s_ready stays high for the next beat. The sixteenth
// beat of a block starts a compression on a single round unit at one round per cycle,
// and s_ready stays low through its 80 rounds and the feed-forward addition. On the last
// beat the unit appends the padding one word per cycle, runs one or two compressions,
// then holds s_ready low until all five digest beats are taken. After the fifth beat the
// unit starts over from the initial values.
`include "sha1_message_digest_unit_assert.svh"

module sha1_message_digest_unit
    import sha1md_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic [2:0]  s_word_bytes,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_final_result
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_HASH = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  fill_reg, fill_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic        marker_reg, marker_next;
    logic        len_phase_reg, len_phase_next;
    logic        ending_reg, ending_next;
    logic        final_reg, final_next;
    logic [2:0]  idx_reg, idx_next;

    ctl_t   ctl;
    sts_t   sts;
    chain_t chain;

    logic  in_beat, out_beat;
    logic [2:0] nb_sat;
    word_t in_word, pad_word;

    sha1md_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sts     (sts),
        .chain   (chain)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_OUT);
    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    // A beat that is not last always counts as four bytes.
    assign nb_sat  = (!s_last_word || s_word_bytes > 3'd4) ? 3'd4 : s_word_bytes;
    assign in_word = (s_last_word && nb_sat != 3'd4) ?
                     last_word_pad(s_message_word, nb_sat[1:0]) : s_message_word;

    // Padding order: pending marker word, zero fill, then the length high and low words.
    always_comb begin
        priority if (marker_reg) begin
            pad_word = PAD_MARKER;
        end else if (fill_reg == 4'd14) begin
            pad_word = bit_len_reg[63:32];
        end else if (fill_reg == 4'd15 && len_phase_reg) begin
            pad_word = bit_len_reg[31:0];
        end else begin
            pad_word = '0;
        end
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bit_len_next   = bit_len_reg;
        marker_next    = marker_reg;
        len_phase_next = len_phase_reg;
        ending_next    = ending_reg;
        final_next     = final_reg;
        idx_next       = idx_reg;
        ctl            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    ctl.load       = 1'b1;
                    ctl.load_word  = in_word;
                    fill_next      = fill_reg + 4'd1;
                    bit_len_next   = bit_len_reg + 64'({nb_sat, 3'b000});
                    marker_next    = s_last_word && (nb_sat == 3'd4);
                    ending_next    = s_last_word;
                    len_phase_next = 1'b0;
                    if (fill_reg == 4'd15) begin
                        ctl.start  = 1'b1;
                        state_next = ST_HASH;
                    end else if (s_last_word) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                ctl.load      = 1'b1;
                ctl.load_word = pad_word;
                fill_next     = fill_reg + 4'd1;
                if (marker_reg) begin
                    marker_next = 1'b0;
                end else if (fill_reg == 4'd14) begin
                    len_phase_next = 1'b1;
                end
                if (fill_reg == 4'd15) begin
                    ctl.start  = 1'b1;
                    state_next = ST_HASH;
                    if (!marker_reg && len_phase_reg) begin
                        final_next = 1'b1;
                    end
                end
            end
            ST_HASH: begin
                if (sts.done) begin
                    if (final_reg) begin
                        state_next = ST_OUT;
                        idx_next   = '0;
                    end else if (ending_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (out_beat) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(NUM_H - 1)) begin
                        ctl.restart    = 1'b1;
                        state_next     = ST_IDLE;
                        idx_next       = '0;
                        bit_len_next   = '0;
                        fill_next      = '0;
                        ending_next    = 1'b0;
                        final_next     = 1'b0;
                        len_phase_next = 1'b0;
                        marker_next    = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bit_len_reg   <= '0;
            marker_reg    <= 1'b0;
            len_phase_reg <= 1'b0;
            ending_reg    <= 1'b0;
            final_reg     <= 1'b0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bit_len_reg   <= bit_len_next;
            marker_reg    <= marker_next;
            len_phase_reg <= len_phase_next;
            ending_reg    <= ending_next;
            final_reg     <= final_next;
            idx_reg       <= idx_next;
        end
    end

    assign m_digest_word  = chain[idx_reg];
    assign m_word_index   = idx_reg;
    assign m_final_result = (idx_reg == 3'(NUM_H - 1));

    `SHA1MD_ASSERT_NEVER(a_in_out_exclusive, aclk, aresetn, s_ready && m_valid, "input and output open together")
    `SHA1MD_ASSERT(a_block_empty_on_output, aclk, aresetn, m_valid |-> fill_reg == 4'd0, "digest shown with a partial block")
    `SHA1MD_ASSERT(a_restart_after_last_beat, aclk, aresetn, out_beat && m_final_result |=> s_ready && bit_len_reg == 64'd0, "no restart after the final digest beat")
    `SHA1MD_ASSERT(a_start_on_full_block, aclk, aresetn, ctl.start |-> fill_reg == 4'd15 && !sts.busy, "compression started on a partial block")

endmodule
